FILE: hdl/assert_macros.svh
// Assertion macros shared by the pressure compensation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on the rising clock edge, disabled during reset.
`define BPC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that holds on every edge, reset included.
`define BPC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/bpc_pkg.sv
// Shared types and constants for the barometer pressure compensation block.
package bpc_pkg;

   typedef struct packed {
      logic [15:0] raw_temp;
      logic [18:0] raw_press;
   } bpc_req_type;

   typedef struct packed {
      logic signed [15:0] temp_tenths;
      logic [17:0]        press_pa;
      logic [14:0]        press_mmhg_tenths;
      logic               div_error;
   } bpc_rsp_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAL_A        = 2'd0,
      CSR_CAL_B        = 2'd1,
      CSR_CAL_C        = 2'd2,
      CSR_OVERSAMPLING = 2'd3
   } bpc_csr_type;

   localparam logic [1:0]         OSS_RESET   = 2'd3;
   localparam logic signed [31:0] B6_OFFSET   = 32'sd4000;
   localparam logic [31:0]        B4_BIAS     = 32'd32768;
   localparam logic [15:0]        B7_SCALE    = 16'd50000;
   localparam logic signed [31:0] P_C1        = 32'sd3038;
   localparam logic signed [31:0] P_C2        = -32'sd7357;
   localparam logic signed [31:0] P_C3        = 32'sd3791;
   localparam logic signed [31:0] T_MAX       = 32'sd32767;
   localparam logic signed [31:0] T_MIN       = -32'sd32768;
   localparam logic signed [31:0] PA_MAX      = 32'sd262143;
   // floor(pa * 100 / 1333) == (pa * MMHG_RECIP) >> MMHG_SHIFT for pa < 2^18
   localparam logic [25:0]        MMHG_RECIP  = 26'd40275388;
   localparam int                 MMHG_SHIFT  = 29;
   localparam logic [14:0]        MMHG_MAX    = 15'd19665;

   // Divider geometry: temperature quotient magnitude and pressure quotient
   localparam int DIV_T_NUM_W = 27;
   localparam int DIV_T_DEN_W = 32;
   localparam int DIV_P_NUM_W = 32;
   localparam int DIV_P_DEN_W = 17;

endpackage

FILE: hdl/barometer_pressure_compensation_top.sv
// Top level of the barometer pressure compensation pipeline.
//
//   port group   dir   handshake            payload
//   req_*        in    req_valid/req_stall  bpc_req_type (raw_temp, raw_press)
//   rsp_*        out   rsp_valid/rsp_stall  bpc_rsp_type (temp, Pa, 0.1 mmHg, error)
//   csr_*        in    csr_we               csr_index, csr_wdata
//
// One item per cycle while the output is not stalled; the pipeline is the two bit-serial
// divider pipelines (27 stages for temperature, 32 for pressure) plus 12 stages.
// Synchronous active-high reset clears valid bits and loads the calibration defaults.
// A stalled result freezes the whole pipeline; req_stall rises only then.
module barometer_pressure_compensation_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  bpc_pkg::bpc_req_type                   req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output bpc_pkg::bpc_rsp_type                   rsp_data,
   input  logic                                   csr_we,
   input  logic [bpc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import bpc_pkg::*;

   `include "assert_macros.svh"

   typedef struct packed {
      logic signed [31:0] x1;
      logic [18:0]        up;
      logic               qneg;
      logic               err;
   } tside_type;

   typedef struct packed {
      logic signed [15:0] t;
      logic               err;
      logic               hi;
   } pside_type;

   // ---------------- configuration ----------------
   logic [63:0] cal_a_ff;
   logic [63:0] cal_b_ff;
   logic [31:0] cal_c_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0;
         cal_b_ff <= '0;
         cal_c_ff <= '0;
         oss_ff   <= OSS_RESET;
      end else if (csr_we) begin
         case (bpc_csr_type'(csr_index))
            CSR_CAL_A:        cal_a_ff <= csr_wdata;
            CSR_CAL_B:        cal_b_ff <= csr_wdata;
            CSR_CAL_C:        cal_c_ff <= csr_wdata[31:0];
            CSR_OVERSAMPLING: oss_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = 32'(signed'(cal_a_ff[15:0]));
   assign ac2 = 32'(signed'(cal_a_ff[31:16]));
   assign ac3 = 32'(signed'(cal_a_ff[47:32]));
   assign ac4 = {16'b0, cal_a_ff[63:48]};
   assign ac5 = {16'b0, cal_b_ff[15:0]};
   assign ac6 = {16'b0, cal_b_ff[31:16]};
   assign b1  = 32'(signed'(cal_b_ff[47:32]));
   assign b2  = 32'(signed'(cal_b_ff[63:48]));
   assign mc  = 32'(signed'(cal_c_ff[15:0]));
   assign md  = 32'(signed'(cal_c_ff[31:16]));

   // ---------------- flow control ----------------
   logic        en;
   logic        rsp_valid_ff;
   bpc_rsp_type rsp_data_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // ---------------- stage 1: raw temperature product ----------------
   logic               s1_valid_ff;
   logic signed [31:0] s1_prod_ff, s1_prod_in;
   logic [18:0]        s1_up_ff;

   assign s1_prod_in = ($signed({16'b0, req_data.raw_temp}) - ac6) * ac5;

   // ---------------- stage 2: temperature divide operands ----------------
   logic               s2_valid_ff;
   logic signed [31:0] x1t_in, den_in, num_in;
   logic [31:0]        num_abs_in, den_abs_in;
   tside_type          s2_side_ff;
   logic [26:0]        s2_num_ff;
   logic [31:0]        s2_den_ff;

   assign x1t_in     = s1_prod_ff >>> 15;
   assign den_in     = x1t_in + md;
   assign num_in     = mc <<< 11;
   assign num_abs_in = num_in[31] ? 32'(-num_in) : 32'(num_in);
   assign den_abs_in = den_in[31] ? 32'(-den_in) : 32'(den_in);

   logic                   dt_valid;
   logic [DIV_T_NUM_W-1:0] dt_quot;
   tside_type              dt_side;

   bpc_div_pipe #(
      .N  (DIV_T_NUM_W),
      .D  (DIV_T_DEN_W),
      .SW ($bits(tside_type))
   ) u_div_t (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_valid_ff),
      .dividend  (s2_num_ff),
      .divisor   (s2_den_ff),
      .side_in   (s2_side_ff),
      .out_valid (dt_valid),
      .quotient  (dt_quot),
      .side_out  (dt_side)
   );

   // ---------------- stage 3: b5, t, b6 ----------------
   logic               s3_valid_ff;
   logic signed [31:0] x2t_in, b5_in, t_in;
   logic signed [31:0] s3_b6_ff, s3_t_ff;
   logic               s3_err_ff;
   logic [18:0]        s3_up_ff;

   assign x2t_in = dt_side.qneg ? -$signed({5'b0, dt_quot}) : $signed({5'b0, dt_quot});
   assign b5_in  = dt_side.x1 + x2t_in;
   assign t_in   = (b5_in + 32'sd8) >>> 4;

   // ---------------- stage 4: products of b6 ----------------
   logic               s4_valid_ff;
   logic signed [31:0] s4_sq_ff, s4_ac2_ff, s4_ac3_ff;
   logic signed [15:0] s4_t_ff, tsat_in;
   logic               s4_err_ff;
   logic [18:0]        s4_up_ff;

   always_comb begin
      if (s3_t_ff > T_MAX) begin
         tsat_in = T_MAX[15:0];
      end else if (s3_t_ff < T_MIN) begin
         tsat_in = T_MIN[15:0];
      end else begin
         tsat_in = s3_t_ff[15:0];
      end
   end

   // ---------------- stage 5: products of sq ----------------
   logic               s5_valid_ff;
   logic signed [31:0] sq_in;
   logic signed [31:0] s5_pb2_ff, s5_pb1_ff, s5_x2a_ff, s5_x1c_ff;
   logic signed [15:0] s5_t_ff;
   logic               s5_err_ff;
   logic [18:0]        s5_up_ff;

   assign sq_in = s4_sq_ff >>> 12;

   // ---------------- stage 6: b3 and x3 ----------------
   logic               s6_valid_ff;
   logic signed [31:0] x3a_in, b3_sum_in, b3_sh_in, b3_in, x3c_in;
   logic signed [31:0] s6_b3_ff, s6_x3c_ff;
   logic signed [15:0] s6_t_ff;
   logic               s6_err_ff;
   logic [18:0]        s6_up_ff;

   assign x3a_in    = (s5_pb2_ff >>> 11) + s5_x2a_ff;
   assign b3_sum_in = (ac1 <<< 2) + x3a_in;
   assign b3_sh_in  = b3_sum_in << oss_ff;
   assign b3_in     = (b3_sh_in + 32'sd2) >>> 2;
   assign x3c_in    = (s5_x1c_ff + (s5_pb1_ff >>> 16) + 32'sd2) >>> 2;

   // ---------------- stage 7: b4 and b7 products ----------------
   logic        s7_valid_ff;
   logic [15:0] scale_in;
   logic [31:0] s7_b4p_ff, s7_b7_ff;
   logic signed [15:0] s7_t_ff;
   logic        s7_err_ff;

   assign scale_in = B7_SCALE >> oss_ff;

   // pressure divide operands
   logic [DIV_P_DEN_W-1:0] b4_in;
   logic [DIV_P_NUM_W-1:0] pnum_in;
   pside_type              pside_in;

   assign b4_in        = s7_b4p_ff[31:15];
   assign pside_in.t   = s7_t_ff;
   assign pside_in.err = s7_err_ff || (b4_in == '0);
   assign pside_in.hi  = s7_b7_ff[31];
   // top bit set: divide then double, else double then divide
   assign pnum_in      = s7_b7_ff[31] ? s7_b7_ff : {s7_b7_ff[30:0], 1'b0};

   logic                   dp_valid;
   logic [DIV_P_NUM_W-1:0] dp_quot;
   pside_type              dp_side;

   bpc_div_pipe #(
      .N  (DIV_P_NUM_W),
      .D  (DIV_P_DEN_W),
      .SW ($bits(pside_type))
   ) u_div_p (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s7_valid_ff),
      .dividend  (pnum_in),
      .divisor   (b4_in),
      .side_in   (pside_in),
      .out_valid (dp_valid),
      .quotient  (dp_quot),
      .side_out  (dp_side)
   );

   // ---------------- stage 9: p and first correction products ----------------
   logic               s9_valid_ff;
   logic signed [31:0] p_in, ps_in;
   logic signed [31:0] s9_p_ff, s9_ma_ff, s9_mb_ff;
   logic signed [15:0] s9_t_ff;
   logic               s9_err_ff;

   assign p_in  = dp_side.hi ? $signed({dp_quot[30:0], 1'b0}) : $signed(dp_quot);
   assign ps_in = p_in >>> 8;

   // ---------------- stage 10 ----------------
   logic               s10_valid_ff;
   logic signed [31:0] s10_p_ff, s10_mc_ff, s10_x2_ff;
   logic signed [15:0] s10_t_ff;
   logic               s10_err_ff;

   // ---------------- stage 11: final pressure, saturated ----------------
   logic               s11_valid_ff;
   logic signed [31:0] pf_in;
   logic [17:0]        pa_in, s11_pa_ff;
   logic signed [15:0] s11_t_ff;
   logic               s11_err_ff;

   assign pf_in = s10_p_ff + (((s10_mc_ff >>> 16) + s10_x2_ff + P_C3) >>> 4);

   always_comb begin
      if (pf_in < 32'sd0) begin
         pa_in = '0;
      end else if (pf_in > PA_MAX) begin
         pa_in = PA_MAX[17:0];
      end else begin
         pa_in = pf_in[17:0];
      end
   end

   // ---------------- stage 12: mmHg reciprocal product ----------------
   logic               s12_valid_ff;
   logic [43:0]        s12_prod_ff;
   logic [17:0]        s12_pa_ff;
   logic signed [15:0] s12_t_ff;
   logic               s12_err_ff;

   // ---------------- valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         s11_valid_ff <= 1'b0;
         s12_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= dt_valid;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s9_valid_ff  <= dp_valid;
         s10_valid_ff <= s9_valid_ff;
         s11_valid_ff <= s10_valid_ff;
         s12_valid_ff <= s11_valid_ff;
         rsp_valid_ff <= s12_valid_ff;
      end
   end

   // ---------------- payload ----------------
   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff <= s1_prod_in;
         s1_up_ff   <= req_data.raw_press;

         s2_side_ff.x1   <= x1t_in;
         s2_side_ff.up   <= s1_up_ff;
         s2_side_ff.qneg <= num_in[31] ^ den_in[31];
         s2_side_ff.err  <= (den_in == '0);
         s2_num_ff       <= num_abs_in[26:0];
         s2_den_ff       <= den_abs_in;

         s3_b6_ff  <= b5_in - B6_OFFSET;
         s3_t_ff   <= t_in;
         s3_err_ff <= dt_side.err;
         s3_up_ff  <= dt_side.up;

         s4_sq_ff  <= s3_b6_ff * s3_b6_ff;
         s4_ac2_ff <= ac2 * s3_b6_ff;
         s4_ac3_ff <= ac3 * s3_b6_ff;
         s4_t_ff   <= tsat_in;
         s4_err_ff <= s3_err_ff;
         s4_up_ff  <= s3_up_ff;

         s5_pb2_ff <= b2 * sq_in;
         s5_pb1_ff <= b1 * sq_in;
         s5_x2a_ff <= s4_ac2_ff >>> 11;
         s5_x1c_ff <= s4_ac3_ff >>> 13;
         s5_t_ff   <= s4_t_ff;
         s5_err_ff <= s4_err_ff;
         s5_up_ff  <= s4_up_ff;

         s6_b3_ff  <= b3_in;
         s6_x3c_ff <= x3c_in;
         s6_t_ff   <= s5_t_ff;
         s6_err_ff <= s5_err_ff;
         s6_up_ff  <= s5_up_ff;

         s7_b4p_ff <= 32'(ac4) * (32'(s6_x3c_ff) + B4_BIAS);
         s7_b7_ff  <= ({13'b0, s6_up_ff} - 32'(s6_b3_ff)) * {16'b0, scale_in};
         s7_t_ff   <= s6_t_ff;
         s7_err_ff <= s6_err_ff;

         s9_p_ff   <= p_in;
         s9_ma_ff  <= ps_in * ps_in;
         s9_mb_ff  <= P_C2 * p_in;
         s9_t_ff   <= dp_side.t;
         s9_err_ff <= dp_side.err;

         s10_p_ff   <= s9_p_ff;
         s10_mc_ff  <= s9_ma_ff * P_C1;
         s10_x2_ff  <= s9_mb_ff >>> 16;
         s10_t_ff   <= s9_t_ff;
         s10_err_ff <= s9_err_ff;

         s11_pa_ff  <= pa_in;
         s11_t_ff   <= s10_t_ff;
         s11_err_ff <= s10_err_ff;

         s12_prod_ff <= 44'(s11_pa_ff) * 44'(MMHG_RECIP);
         s12_pa_ff   <= s11_pa_ff;
         s12_t_ff    <= s11_t_ff;
         s12_err_ff  <= s11_err_ff;

         if (s12_err_ff) begin
            rsp_data_ff <= '{temp_tenths: '0, press_pa: '0,
                             press_mmhg_tenths: '0, div_error: 1'b1};
         end else begin
            rsp_data_ff <= '{temp_tenths: s12_t_ff, press_pa: s12_pa_ff,
                             press_mmhg_tenths: s12_prod_ff[MMHG_SHIFT +: 15],
                             div_error: 1'b0};
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   `BPC_ASSERT(a_err_zero, clock, reset,
      (rsp_valid_ff && rsp_data_ff.div_error) |->
         (rsp_data_ff.press_pa == '0 && rsp_data_ff.temp_tenths == '0
          && rsp_data_ff.press_mmhg_tenths == '0),
      "divide error with nonzero result")
   `BPC_ASSERT(a_mmhg_range, clock, reset,
      rsp_valid_ff |-> (rsp_data_ff.press_mmhg_tenths <= MMHG_MAX),
      "mmHg result above saturated pressure")
   `BPC_ASSERT(a_freeze, clock, reset,
      !en |=> ($stable(s6_valid_ff) && $stable(s12_valid_ff) && $stable(s6_b3_ff)),
      "pipeline moved while output stalled")

endmodule

FILE: hdl/bpc_div_pipe.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
module bpc_div_pipe #(
   parameter int N  = 32,
   parameter int D  = 32,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [N-1:0]  dividend,
   input  logic [D-1:0]  divisor,
   input  logic [SW-1:0] side_in,
   output logic          out_valid,
   output logic [N-1:0]  quotient,
   output logic [SW-1:0] side_out
);

   logic          vld_ff  [1:N];
   logic [N-1:0]  num_ff  [1:N];
   logic [D-1:0]  dvs_ff  [1:N];
   logic [SW-1:0] side_ff [1:N];
   logic [D-1:0]  rem_ff  [1:N-1];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic          v_c;
      logic [D-1:0]  rem_c;
      logic [N-1:0]  num_c;
      logic [D-1:0]  dvs_c;
      logic [SW-1:0] side_c;
      logic [D:0]    trial;
      logic [D:0]    diff;
      logic          q_bit;

      if (i == 0) begin : g_first
         assign v_c    = in_valid;
         assign rem_c  = '0;
         assign num_c  = dividend;
         assign dvs_c  = divisor;
         assign side_c = side_in;
      end else begin : g_rest
         assign v_c    = vld_ff[i];
         assign rem_c  = rem_ff[i];
         assign num_c  = num_ff[i];
         assign dvs_c  = dvs_ff[i];
         assign side_c = side_ff[i];
      end

      assign trial = {rem_c, num_c[N-1]};
      assign diff  = trial - {1'b0, dvs_c};
      assign q_bit = !diff[D];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= v_c;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[i+1]  <= {num_c[N-2:0], q_bit};
            dvs_ff[i+1]  <= dvs_c;
            side_ff[i+1] <= side_c;
         end
      end

      if (i < N-1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i+1] <= q_bit ? diff[D-1:0] : trial[D-1:0];
            end
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign quotient  = num_ff[N];
   assign side_out  = side_ff[N];

endmodule
